>>> rtl/kpd_seg_pkg.sv
// ----------------------------------------------------------------------------
// kpd_seg_pkg: shared types and constants for the keypad entry display
// Request payload types, register indexes, blank code and the two lookup
// tables (key remap and seven-segment patterns).
// ----------------------------------------------------------------------------
package kpd_seg_pkg;

  // request operations
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_SCANS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_DIVIDE = 2'd1;

  localparam logic [CFG_DAT_W-1:0] ACCEPT_SCANS_RST   = 2'd2;
  localparam logic [CFG_DAT_W-1:0] REFRESH_DIVIDE_RST = 2'd3;

  // digit store codes: 0..15 hex digit, 16 blank
  localparam int unsigned CODE_W = 5;
  localparam logic [CODE_W-1:0] BLANK_CODE = 5'd16;

  localparam logic [1:0] PRESS_MAX = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [3:0] row_lines;
    logic [3:0] column_lines;
  } in_item_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [7:0] digit_enable;
    logic       key_accepted;
    logic [3:0] key_digit;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_write_t;

  // decoded line nibble: hit when exactly one line is pulled low
  typedef struct packed {
    logic       hit;
    logic [1:0] pos;
  } line_hit_t;

  function automatic line_hit_t decode_lines(input logic [3:0] lines);
    line_hit_t res;
    res = '{hit: 1'b1, pos: 2'd0};
    case (~lines)
      4'b0001: res.pos = 2'd0;
      4'b0010: res.pos = 2'd1;
      4'b0100: res.pos = 2'd2;
      4'b1000: res.pos = 2'd3;
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

  // key index (row + 4*column) to the digit printed on the key
  function automatic logic [3:0] key_remap(input logic [3:0] idx);
    logic [3:0] d;
    case (idx)
      4'd0:    d = 4'd1;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd3;
      4'd3:    d = 4'd10;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd5;
      4'd6:    d = 4'd6;
      4'd7:    d = 4'd11;
      4'd8:    d = 4'd7;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd9;
      4'd11:   d = 4'd12;
      4'd12:   d = 4'd14;
      4'd13:   d = 4'd0;
      4'd14:   d = 4'd15;
      default: d = 4'd13;
    endcase
    return d;
  endfunction

  // segment pattern, bit0 = a; blank and anything above it is dark
  function automatic logic [6:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [6:0] s;
    case (code)
      5'd0:    s = 7'h3f;
      5'd1:    s = 7'h06;
      5'd2:    s = 7'h5b;
      5'd3:    s = 7'h4f;
      5'd4:    s = 7'h66;
      5'd5:    s = 7'h6d;
      5'd6:    s = 7'h7d;
      5'd7:    s = 7'h07;
      5'd8:    s = 7'h7f;
      5'd9:    s = 7'h6f;
      5'd10:   s = 7'h77;
      5'd11:   s = 7'h7c;
      5'd12:   s = 7'h39;
      5'd13:   s = 7'h5e;
      5'd14:   s = 7'h79;
      5'd15:   s = 7'h71;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/kpd_seg_chan_if.sv
// ----------------------------------------------------------------------------
// kpd_seg_chan_if: valid/ready channel
// Carries one payload of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface kpd_seg_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/keypad_entry_segment_display.sv
// ----------------------------------------------------------------------------
// keypad_entry_segment_display: keypad entry with multiplexed digit display
// Debounced 4x4 keypad entry into a digit buffer that drives a multiplexed
// seven-segment display, one scan or refresh tick per request.
// ----------------------------------------------------------------------------
// Each request on in_ch is a keypad scan (active-low row and column nibbles)
// or a display refresh tick, and gives exactly one result on out_ch. The
// block takes one request per clock while the result side keeps up: a
// request is held in an input register, is processed in one pass into the
// result register and is read out from there. A scan needs exactly one
// low row bit and one low column bit to count as a key; accept_scans
// consecutive such scans accept the key once until a keyless scan is seen.
// The accepted key is remapped to a hex digit and shifted into digit 0 of
// the buffer, which starts all blank. Every refresh_divide ticks the display
// moves to the next digit and drives its pattern with an active-low select.
// cfg_ch is always ready; registers are meant to be written while idle.
// ----------------------------------------------------------------------------
module keypad_entry_segment_display #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  kpd_seg_chan_if.sink        in_ch,
  kpd_seg_chan_if.source      out_ch,
  kpd_seg_chan_if.sink        cfg_ch
);
  import kpd_seg_pkg::*;

  localparam int unsigned POS_W = $clog2(DIGIT_COUNT);

  // configuration registers
  logic [CFG_DAT_W-1:0] accept_scans_r;
  logic [CFG_DAT_W-1:0] refresh_divide_r;

  // input stage
  logic      s1_valid_r;
  in_item_t  s1_item_r;

  // result stage
  logic      out_valid_r;
  out_item_t out_item_r;

  // key and display state
  logic [CODE_W-1:0] store_r   [DIGIT_COUNT];
  logic [CODE_W-1:0] store_nxt [DIGIT_COUNT];
  logic [1:0]        press_r, press_nxt;
  logic              latched_r, latched_nxt;
  logic [1:0]        tick_r, tick_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [6:0]        seg_r, seg_nxt;
  logic [7:0]        sel_r, sel_nxt;

  // handshake
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // scan decode
  line_hit_t  row_hit;
  line_hit_t  col_hit;
  logic [1:0] press_inc;
  logic       accept_now;
  logic [3:0] new_digit;

  // tick path
  logic [2:0]       tick_inc;
  logic [POS_W:0]   pos_inc;
  logic [POS_W-1:0] pos_adv;

  always_comb begin
    row_hit    = decode_lines(s1_item_r.row_lines);
    col_hit    = decode_lines(s1_item_r.column_lines);
    // press counter saturates at three
    press_inc  = (press_r == PRESS_MAX) ? PRESS_MAX : press_r + 2'd1;
    accept_now = (s1_item_r.operation == OP_SCAN) && row_hit.hit && col_hit.hit
                 && !latched_r && (press_inc >= accept_scans_r);
    new_digit  = key_remap({col_hit.pos, row_hit.pos});

    tick_inc = {1'b0, tick_r} + 3'd1;
    pos_inc  = {1'b0, pos_r} + (POS_W+1)'(1);
    // wrap the scan position at the digit count
    pos_adv  = (pos_inc >= (POS_W+1)'(DIGIT_COUNT)) ? '0 : pos_inc[POS_W-1:0];
  end

  always_comb begin
    store_nxt   = store_r;
    press_nxt   = press_r;
    latched_nxt = latched_r;
    tick_nxt    = tick_r;
    pos_nxt     = pos_r;
    seg_nxt     = seg_r;
    sel_nxt     = sel_r;

    if (s1_item_r.operation == OP_SCAN) begin
      if (row_hit.hit && col_hit.hit) begin
        press_nxt = press_inc;
        if (accept_now) begin
          latched_nxt  = 1'b1;
          store_nxt[0] = {1'b0, new_digit};
          for (int i = 1; i < DIGIT_COUNT; i++) begin
            store_nxt[i] = store_r[i-1];
          end
        end
      end else begin
        // no key or an ambiguous pattern releases the latch
        press_nxt   = '0;
        latched_nxt = 1'b0;
      end
    end else begin
      if (tick_inc >= {1'b0, refresh_divide_r}) begin
        tick_nxt = '0;
        pos_nxt  = pos_adv;
        seg_nxt  = seg_pattern(store_r[pos_adv]);
        // digits beyond the eighth have no select line
        if (5'(pos_adv) < 5'd8) begin
          sel_nxt = ~(8'd1 << pos_adv);
        end else begin
          sel_nxt = 8'hff;
        end
      end else begin
        tick_nxt = tick_inc[1:0];
      end
    end
  end

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_scans_r   <= ACCEPT_SCANS_RST;
      refresh_divide_r <= REFRESH_DIVIDE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_ACCEPT_SCANS:   accept_scans_r   <= cfg_ch.data.value;
        REG_REFRESH_DIVIDE: refresh_divide_r <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_ch.data;
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      press_r     <= '0;
      latched_r   <= 1'b0;
      tick_r      <= '0;
      pos_r       <= '0;
      seg_r       <= '0;
      sel_r       <= 8'hff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store_r[i] <= BLANK_CODE;
      end
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        press_r   <= press_nxt;
        latched_r <= latched_nxt;
        tick_r    <= tick_nxt;
        pos_r     <= pos_nxt;
        seg_r     <= seg_nxt;
        sel_r     <= sel_nxt;
        store_r   <= store_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r.segments     <= seg_nxt;
      out_item_r.digit_enable <= sel_nxt;
      out_item_r.key_accepted <= accept_now;
      out_item_r.key_digit    <= accept_now ? new_digit : 4'd0;
    end
  end

endmodule

>>> bench/tb_keypad_entry_segment_display.sv
// ----------------------------------------------------------------------------
// tb_keypad_entry_segment_display: self-checking bench for the keypad display
// Sends keypad scans and refresh ticks under random source gaps and sink
// stalls, predicts every readout from a local model of the debounce, digit
// buffer and display multiplexer, and compares each readout field by field.
// Both registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_keypad_entry_segment_display;

  import kpd_seg_pkg::*;

  localparam int DIGITS      = 8;
  localparam int STUCK_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 205;

  logic clk = 1'b0;
  logic rst_n;

  kpd_seg_chan_if #(.payload_t(in_item_t))   in_ch ();
  kpd_seg_chan_if #(.payload_t(out_item_t))  out_ch ();
  kpd_seg_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  keypad_entry_segment_display #(.DIGIT_COUNT(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // request stream waiting to be sent, and readouts still owed by the block
  in_item_t  pending_reqs[$];
  out_item_t expected_readouts[$];
  int        fail_count = 0;

  // local copy of the block state
  logic [CODE_W-1:0] shown_digits [DIGITS];
  int unsigned       press_run;
  bit                key_held;
  int unsigned       tick_run;
  int unsigned       scan_pos;
  logic [6:0]        seg_drive;
  logic [7:0]        sel_drive;
  logic [1:0]        accept_need;
  logic [1:0]        refresh_ticks;

  // printed legend of each key, indexed by row + 4 * column
  logic [3:0] key_legend [16] = '{4'd1, 4'd2, 4'd3, 4'd10, 4'd4, 4'd5, 4'd6, 4'd11,
                                  4'd7, 4'd8, 4'd9, 4'd12, 4'd14, 4'd0, 4'd15, 4'd13};
  // segment font for codes 0..15, then blank
  logic [6:0] seg_font [17] = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
                                7'h7f, 7'h6f, 7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71,
                                7'h00};

  // exactly one line pulled low gives its position
  function automatic bit single_low(input logic [3:0] lines, output logic [1:0] pos);
    logic [3:0] act;
    act = ~lines;
    pos = 2'd0;
    for (int b = 0; b < 4; b++)
      if (act[b]) pos = 2'(b);
    return $countones(act) == 1;
  endfunction

  // one scan or tick through the keypad and display model
  function automatic out_item_t advance_keypad_display(input in_item_t req);
    out_item_t  res;
    logic [1:0] row_pos, col_pos;
    bit         row_hit, col_hit;
    int unsigned code;
    res = '0;
    if (req.operation == OP_SCAN) begin
      row_hit = single_low(req.row_lines, row_pos);
      col_hit = single_low(req.column_lines, col_pos);
      if (row_hit && col_hit) begin
        if (press_run < 3) press_run++;
        // zero in the register behaves as one
        if (!key_held && press_run >= accept_need) begin
          key_held         = 1'b1;
          res.key_accepted = 1'b1;
          res.key_digit    = key_legend[{col_pos, row_pos}];
          for (int i = DIGITS - 1; i > 0; i--) shown_digits[i] = shown_digits[i-1];
          shown_digits[0] = {1'b0, res.key_digit};
        end
      end else begin
        // no key: debounce starts over
        key_held  = 1'b0;
        press_run = 0;
      end
    end else begin
      if (tick_run + 1 >= refresh_ticks) begin
        tick_run  = 0;
        scan_pos  = (scan_pos + 1) % DIGITS;
        code      = shown_digits[scan_pos];
        if (code > 16) code = 16;
        seg_drive = seg_font[code];
        sel_drive = ~(8'b1 << scan_pos);
      end else begin
        tick_run++;
      end
    end
    res.segments     = seg_drive;
    res.digit_enable = sel_drive;
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------- driver
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      send_gap = 0;
    end else begin
      // accepted request: predict its readout
      if (in_ch.valid && in_ch.ready)
        expected_readouts.push_back(advance_keypad_display(in_ch.data));
      // load the next request once the current one is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_reqs.pop_front();
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = draw_gap();
            if ($urandom_range(0, 149) == 0) send_calm = $urandom_range(30, 120);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int stall_left = 0;
  int stall_calm = 0;

  task automatic check_readout(input out_item_t got);
    out_item_t want;
    if (expected_readouts.size() == 0) begin
      $error("readout with nothing expected: %p", got);
      fail_count++;
      return;
    end
    want = expected_readouts.pop_front();
    if (got.segments !== want.segments) begin
      $error("segments: expected %h, got %h", want.segments, got.segments);
      fail_count++;
    end
    if (got.digit_enable !== want.digit_enable) begin
      $error("digit_enable: expected %h, got %h", want.digit_enable, got.digit_enable);
      fail_count++;
    end
    if (got.key_accepted !== want.key_accepted) begin
      $error("key_accepted: expected %b, got %b", want.key_accepted, got.key_accepted);
      fail_count++;
    end
    if (got.key_digit !== want.key_digit) begin
      $error("key_digit: expected %h, got %h", want.key_digit, got.key_digit);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_readout(out_ch.data);
      // random sink stalls, with calm stretches of steady ready
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (stall_calm > 0) begin
          stall_calm--;
        end else begin
          stall_left = draw_gap();
          if ($urandom_range(0, 149) == 0) stall_calm = $urandom_range(30, 120);
        end
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", stuck_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  function automatic logic [3:0] key_lines(input int pos);
    return ~(4'b0001 << pos);
  endfunction

  // nibble that never reads as a single pressed line
  function automatic logic [3:0] dead_lines();
    logic [3:0] v;
    do v = 4'($urandom_range(0, 15)); while ($countones(~v) == 1);
    return v;
  endfunction

  function automatic void queue_scan(input logic [3:0] rows, input logic [3:0] cols);
    pending_reqs.push_back('{operation: OP_SCAN, row_lines: rows, column_lines: cols});
  endfunction

  // tick carries junk on the line fields, which must be ignored
  function automatic void queue_tick();
    pending_reqs.push_back('{operation: OP_TICK,
                             row_lines: 4'($urandom_range(0, 15)),
                             column_lines: 4'($urandom_range(0, 15))});
  endfunction

  function automatic void queue_release();
    case ($urandom_range(0, 3))
      0, 1:    queue_scan(4'hf, 4'hf);
      2:       queue_scan(dead_lines(), 4'($urandom_range(0, 15)));
      default: queue_scan(4'($urandom_range(0, 15)), dead_lines());
    endcase
  endfunction

  // block must be idle: nothing queued, in flight or owed
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_readouts.size() != 0)
      @(posedge clk);
  endtask

  // both registers back to back, valid held across the pair
  task automatic configure(input logic [1:0] scans, input logic [1:0] ticks);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: REG_ACCEPT_SCANS, value: scans};
    do @(posedge clk); while (!cfg_ch.ready);
    accept_need = scans;
    cfg_ch.data <= '{index: REG_REFRESH_DIVIDE, value: ticks};
    do @(posedge clk); while (!cfg_ch.ready);
    refresh_ticks = ticks;
    cfg_ch.valid <= 1'b0;
  endtask

  logic [1:0] phase_scans [PHASES] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2, 2'd2};
  logic [1:0] phase_ticks [PHASES] = '{2'd0, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd1, 2'd3};

  initial begin
    int start_size, queued, pick, key, presses;
    // known levels from time zero
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    foreach (shown_digits[i]) shown_digits[i] = BLANK_CODE;
    press_run     = 0;
    key_held      = 1'b0;
    tick_run      = 0;
    scan_pos      = 0;
    seg_drive     = 7'h00;
    sel_drive     = 8'hff;
    accept_need   = ACCEPT_SCANS_RST;
    refresh_ticks = REFRESH_DIVIDE_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings
    repeat (3) queue_tick();               // first advance shows a blank digit
    repeat (3) queue_scan(4'he, 4'he);     // accept on second, then held
    queue_scan(4'hf, 4'hf);                // release
    repeat (2) queue_scan(4'h7, 4'h7);     // last key of the matrix
    queue_scan(4'he, 4'hf);                // row hit without a column: no key
    queue_scan(4'h7, 4'h7);                // count restarted, not yet accepted
    queue_scan(4'hf, 4'he);                // column without a row
    queue_scan(4'hc, 4'he);                // two rows low
    queue_scan(4'h0, 4'h0);                // everything low
    repeat (2) queue_scan(4'hb, 4'hd);
    repeat (8) queue_tick();               // advance the display twice at the reset divide
    wait_drained();

    // random phases, each behind a register change while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(phase_scans[ph], phase_ticks[ph]);
      start_size = pending_reqs.size();
      queued = 0;
      while (queued < PHASE_REQS) begin
        start_size = pending_reqs.size();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // a held key: several pressed scans, ticks mixed in, then release
          key     = $urandom_range(0, 15);
          presses = $urandom_range(1, 5);
          repeat (presses) begin
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) queue_tick();
            queue_scan(key_lines(key % 4), key_lines(key / 4));
          end
          repeat ($urandom_range(1, 2)) queue_release();
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6)) queue_tick();
        end else begin
          queue_scan(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
        queued += pending_reqs.size() - start_size;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_readouts.size() != 0) begin
      $error("readouts never delivered: %0d", expected_readouts.size());
      fail_count++;
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/kpd_seg_pkg.sv
rtl/kpd_seg_chan_if.sv
rtl/keypad_entry_segment_display.sv
bench/tb_keypad_entry_segment_display.sv
